@@ hdl/lcd_pixel_shadow_writer_defines.svh @@
// assertion macros used by the controller of the lcd pixel shadow writer rtl
// needs signals named clk and rst_n in the module that uses them
`ifndef LCD_PIXEL_SHADOW_WRITER_DEFINES_SVH
`define LCD_PIXEL_SHADOW_WRITER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LPSW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define LPSW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/lpsw_pkg.sv @@
// shared types and constants of the lcd pixel shadow writer
// used by the controller, the datapath and the top level
`default_nettype none

package lpsw_pkg;

  localparam int LPSW_COLUMNS = 128;
  localparam int LPSW_PAGES   = 8;

  // lcd command bytes
  localparam logic [7:0] CMD_PAGE     = 8'hB0;
  localparam logic [7:0] CMD_COL_HIGH = 8'h10;

  // result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_CMD    = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;

  // request operations
  localparam logic OP_SET = 1'b0;
  localparam logic OP_GET = 1'b1;

  // place of each byte in the four-byte lcd transaction sequence
  localparam logic [1:0] SEQ_PAGE   = 2'd0;
  localparam logic [1:0] SEQ_COL_HI = 2'd1;
  localparam logic [1:0] SEQ_COL_LO = 2'd2;
  localparam logic [1:0] SEQ_DATA   = 2'd3;

  typedef struct packed {
    logic       clear_wr;
    logic       capture;
    logic       eval;
    logic [1:0] seq;
  } lpsw_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic last;
  } lpsw_stat_t;

endpackage

`default_nettype wire

@@ hdl/lpsw_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module lpsw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/lpsw_ctrl.sv @@
// controller state machine of the lcd pixel shadow writer
// depends on lpsw_pkg and lcd_pixel_shadow_writer_defines.svh
`default_nettype none
`include "lcd_pixel_shadow_writer_defines.svh"

module lpsw_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  output lpsw_pkg::lpsw_cmd_t  cmd,
  input  wire lpsw_pkg::lpsw_stat_t stat
);
  import lpsw_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EVAL  = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] seq_r, seq_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    seq_nxt   = seq_r;
    case (state_r)
      S_CLEAR: begin
        if (stat.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_OUT;
        seq_nxt   = SEQ_PAGE;
      end
      S_OUT: begin
        if (out_ready) begin
          if (stat.last) begin
            state_nxt = S_IDLE;
          end else begin
            seq_nxt = seq_r + 2'd1;
          end
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      seq_r   <= SEQ_PAGE;
    end else begin
      state_r <= state_nxt;
      seq_r   <= seq_nxt;
    end
  end

  always_comb begin
    cmd.clear_wr = (state_r == S_CLEAR);
    cmd.capture  = (state_r == S_IDLE) && in_valid;
    cmd.eval     = (state_r == S_EVAL);
    cmd.seq      = seq_r;
  end

  `LPSW_ASSERT_NOW(a_no_accept_while_result, in_ready, !out_valid, "input taken while result pending")
  `LPSW_ASSERT_NOW(a_no_accept_in_clear, cmd.clear_wr, !in_ready, "input taken during clearing pass")
  `LPSW_ASSERT_NEXT(a_accept_then_eval, in_valid && in_ready, cmd.eval, "accepted request not evaluated")
  `LPSW_ASSERT_NEXT(a_last_then_idle, out_valid && out_ready && stat.last, in_ready, "no return to idle after last")

endmodule

`default_nettype wire

@@ hdl/lpsw_datapath.sv @@
// datapath of the lcd pixel shadow writer: shadow store, request registers,
// read-modify-write and result byte selection; depends on lpsw_pkg and lpsw_ram
`default_nettype none

module lpsw_datapath #(
  parameter int COLUMNS = lpsw_pkg::LPSW_COLUMNS,
  parameter int PAGES   = lpsw_pkg::LPSW_PAGES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire lpsw_pkg::lpsw_cmd_t cmd,
  output lpsw_pkg::lpsw_stat_t     stat,
  input  wire logic        cfg_wr,
  input  wire logic        cfg_enable,
  input  wire logic        in_operation,
  input  wire logic [6:0]  in_pixel_x,
  input  wire logic [5:0]  in_pixel_y,
  input  wire logic        in_color,
  output logic      [1:0]  out_kind,
  output logic      [7:0]  out_lcd_byte,
  output logic             out_pixel_value,
  output logic             out_status,
  output logic             out_last
);
  import lpsw_pkg::*;

  localparam int DEPTH = PAGES * COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int IDX_W = 13;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  logic          enable_r;
  logic [AW-1:0] clr_cnt_r;

  logic          op_r, color_r, onscreen_r;
  logic [6:0]    x_r;
  logic [5:0]    y_r;
  logic [AW-1:0] idx_r;

  logic          single_r, pix_r, st_r;
  logic [7:0]    newv_r;

  logic [IDX_W-1:0] idx_full;
  logic             onscreen_in;
  logic [7:0]       rdata, mask, newv;
  logic             ok, changed, upd_we;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [7:0]       ram_wdata;

  // page times columns plus column, only meaningful on screen
  assign idx_full = IDX_W'(in_pixel_y[5:3]) * IDX_W'(COLUMNS) + IDX_W'(in_pixel_x);
  assign onscreen_in = (9'(in_pixel_x) < 9'(COLUMNS)) && (5'(in_pixel_y[5:3]) < 5'(PAGES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      clr_cnt_r <= '0;
    end else begin
      if (cfg_wr) begin
        enable_r <= cfg_enable;
      end
      if (cmd.clear_wr) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
    end
  end

  assign stat.clear_done = cmd.clear_wr && (clr_cnt_r == LAST_ADDR);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= in_operation;
      color_r    <= in_color;
      x_r        <= in_pixel_x;
      y_r        <= in_pixel_y;
      idx_r      <= idx_full[AW-1:0];
      onscreen_r <= onscreen_in;
    end
  end

  // rdata holds the addressed byte during eval
  assign mask    = 8'(1) << y_r[2:0];
  assign newv    = color_r ? (rdata | mask) : (rdata & ~mask);
  assign ok      = enable_r && onscreen_r;
  assign changed = (newv != rdata);
  assign upd_we  = cmd.eval && (op_r == OP_SET) && ok && changed;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      newv_r <= newv;
      if (op_r == OP_GET) begin
        single_r <= 1'b1;
        pix_r    <= ok && rdata[y_r[2:0]];
        st_r     <= 1'b0;
      end else if (!ok) begin
        single_r <= 1'b1;
        pix_r    <= 1'b0;
        st_r     <= 1'b1;
      end else begin
        single_r <= !changed;
        pix_r    <= 1'b0;
        st_r     <= 1'b0;
      end
    end
  end

  // clearing pass writes zeros, otherwise the updated byte
  assign ram_we    = cmd.clear_wr || upd_we;
  assign ram_waddr = cmd.clear_wr ? clr_cnt_r : idx_r;
  assign ram_wdata = cmd.clear_wr ? 8'h00 : newv;

  lpsw_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_shadow (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_full[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    out_kind        = KIND_STATUS;
    out_lcd_byte    = 8'h00;
    out_pixel_value = 1'b0;
    out_status      = 1'b0;
    out_last        = 1'b0;
    if (single_r) begin
      out_pixel_value = pix_r;
      out_status      = st_r;
      out_last        = 1'b1;
    end else begin
      case (cmd.seq)
        SEQ_PAGE: begin
          out_kind     = KIND_CMD;
          out_lcd_byte = CMD_PAGE | {5'd0, y_r[5:3]};
        end
        SEQ_COL_HI: begin
          out_kind     = KIND_CMD;
          out_lcd_byte = CMD_COL_HIGH | {5'd0, x_r[6:4]};
        end
        SEQ_COL_LO: begin
          out_kind     = KIND_CMD;
          out_lcd_byte = {4'd0, x_r[3:0]};
        end
        SEQ_DATA: begin
          out_kind     = KIND_DATA;
          out_lcd_byte = newv_r;
          out_last     = 1'b1;
        end
        default: begin
          out_kind = KIND_STATUS;
        end
      endcase
    end
  end

  assign stat.last = out_last;

endmodule

`default_nettype wire

@@ hdl/lcd_pixel_shadow_writer.sv @@
// Shadow framebuffer for a page-addressed monochrome LCD, PAGES pages of COLUMNS
// column bytes (bit 0 is the top pixel of a page). After reset the block runs a
// clearing pass over the PAGES*COLUMNS bytes (1024 at the default size) of the
// shadow store, one byte per cycle, during which in_ready stays low; enable
// writes on the cfg port are taken at any time. A request is then handled one
// at a time: accept, read the stored byte from the shadow ram and evaluate,
// then the results are shown on the output register one per cycle while
// out_ready is high. A get, a refused set or a set that leaves the byte
// unchanged gives a single result; a set that changes the byte emits page,
// column high, column low and data bytes.
// Depends on lpsw_pkg, lpsw_ctrl and lpsw_datapath.
`default_nettype none

module lcd_pixel_shadow_writer #(
  parameter int COLUMNS = lpsw_pkg::LPSW_COLUMNS,
  parameter int PAGES   = lpsw_pkg::LPSW_PAGES
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_enable,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_operation,
  input  wire logic [6:0] in_pixel_x,
  input  wire logic [5:0] in_pixel_y,
  input  wire logic       in_color,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [1:0] out_kind,
  output logic      [7:0] out_lcd_byte,
  output logic            out_pixel_value,
  output logic            out_status,
  output logic            out_last
);
  import lpsw_pkg::*;

  lpsw_cmd_t  cmd;
  lpsw_stat_t stat;

  assign cfg_ready = 1'b1;

  lpsw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  lpsw_datapath #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_wr          (cfg_valid && cfg_ready),
    .cfg_enable      (cfg_enable),
    .in_operation    (in_operation),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .in_color        (in_color),
    .out_kind        (out_kind),
    .out_lcd_byte    (out_lcd_byte),
    .out_pixel_value (out_pixel_value),
    .out_status      (out_status),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire
